### design/aops_pkg.sv
`timescale 1ns / 1ps

package aops_pkg;

  localparam int SLOTS       = 16;
  localparam int SLOT_W      = 4;
  localparam int ADDR_W      = $clog2(SLOTS);
  localparam int MAX_RESULTS = 15;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int EDGE_W      = 34;
  localparam int FRAC_W      = 12;
  localparam int ID_W        = 16;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_SCAN = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [SLOT_W-1:0]  slot;
    logic [15:0]        entity_id;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic [15:0]        box_width;
    logic [15:0]        box_height;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] first_entity;
    logic [15:0] second_entity;
    logic        last;
  } out_item_t;

  // One table row as stored in the box memory.
  typedef struct packed {
    logic [ID_W-1:0]          id;
    logic signed [EDGE_W-1:0] left;
    logic signed [EDGE_W-1:0] right;
    logic signed [EDGE_W-1:0] top;
    logic signed [EDGE_W-1:0] bottom;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic capture;
    logic calc;
    logic write;
    logic lat_row;
    logic scan;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_load;
    logic row_occ;
    logic row_last;
    logic idx_last;
    logic hit_now;
    logic cnt_full;
  } ctrl_sts_t;

endpackage

### design/aabb_pair_overlap_scan_core.sv
`timescale 1ns / 1ps

// Box table with a pairwise overlap scan.
// Input beats use a start/busy handshake: a beat is taken at a clock edge
// where start is high and busy is low. A load beat writes one table slot with
// the owner id and the box corners built from the 20.12 anchor and the integer
// offset and size. A scan beat compares one row against every later occupied
// slot and reports up to MAX_RESULTS strict overlaps as result beats, in slot
// order, with last set on the final one; a scan without hits, and every
// load, gives a single result beat with hit low and last high.
// Result beats appear on out_item for one cycle, flagged by out_valid. The
// receiver cannot stall, so there is no backpressure on this side.
// Steps: a load passes dispatch and write; a scan of an occupied row passes
// dispatch, row latch, a scan of the later slots and finish, reading the
// box memory one slot per cycle via its single read port; an empty row goes
// from dispatch to finish. Busy falls in the cycle that presents the final
// result beat, so the next beat can be accepted at the edge that ends it.
// Reset (synchronous, active low) marks every slot empty; the stored corners
// are not cleared and are only ever used for occupied slots.
module aabb_pair_overlap_scan_core
  import aops_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // The controller sequences load and scan steps; the datapath holds the
  // table, the row under test and the held-back hit.
  aops_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  aops_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Every result beat is produced by work already under way.
  a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without an item in flight");

  // An accepted beat keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // A reported pair always names an occupied row.
  a_hit_has_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.hit) |-> (out_item.first_entity != '0))
    else $error("hit reported for an empty row");

  // A no-hit result is always the only and final one.
  a_nohit_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.hit) |-> out_item.last)
    else $error("no-hit result without last");

  // Nothing follows the final result of an item in the next cycle.
  a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last) |=> !out_valid)
    else $error("result beat right after last");

endmodule

### design/aops_ram.sv
`timescale 1ns / 1ps

module aops_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/aops_ctrl.sv
`timescale 1ns / 1ps

module aops_ctrl
  import aops_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd,
  output logic      busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_WRITE,
    S_ROWLAT,
    S_SCAN,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.capture = start;
        if (start) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        // The row read is issued here by default addressing.
        if (sts.is_load) begin
          cmd.calc  = 1'b1;
          state_nxt = S_WRITE;
        end else if (sts.row_occ) begin
          state_nxt = S_ROWLAT;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = S_IDLE;
      end
      S_ROWLAT: begin
        cmd.lat_row = 1'b1;
        state_nxt   = sts.row_last ? S_FIN : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.idx_last || (sts.hit_now && sts.cnt_full)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

### design/aops_dp.sv
`timescale 1ns / 1ps

module aops_dp
  import aops_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  ctrl_cmd_t cmd,
  output ctrl_sts_t sts,
  output logic      out_valid,
  output out_item_t out_item
);

  in_item_t                 item_r;
  entry_t                   row_r;
  logic signed [EDGE_W-1:0] left_r, top_r;
  logic [SLOTS-1:0]         occ_r;
  logic [ADDR_W-1:0]        idx_r, rd_addr;
  logic [ID_W-1:0]          pend_id_r;
  logic                     pend_v_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_item_r, out_item_nxt;
  entry_t                   wr_entry, rd_entry;
  logic [ENTRY_W-1:0]       rd_bits;
  logic [ADDR_W-1:0]        wr_addr;
  logic                     overlap;

  assign wr_addr = item_r.slot[ADDR_W-1:0];

  always_comb begin
    case ({cmd.lat_row, cmd.scan})
      2'b10:   rd_addr = wr_addr + ADDR_W'(1);
      2'b01:   rd_addr = idx_r + ADDR_W'(1);
      default: rd_addr = wr_addr;
    endcase
  end

  always_comb begin
    wr_entry.id     = item_r.entity_id;
    wr_entry.left   = left_r;
    wr_entry.right  = left_r + $signed({6'b0, item_r.box_width, {FRAC_W{1'b0}}});
    wr_entry.top    = top_r;
    wr_entry.bottom = top_r + $signed({6'b0, item_r.box_height, {FRAC_W{1'b0}}});
  end

  aops_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .raddr (rd_addr),
    .rdata (rd_bits)
  );

  assign rd_entry = entry_t'(rd_bits);

  assign overlap = ($signed(row_r.left)   < $signed(rd_entry.right))  &&
                   ($signed(row_r.right)  > $signed(rd_entry.left))   &&
                   ($signed(row_r.top)    < $signed(rd_entry.bottom)) &&
                   ($signed(row_r.bottom) > $signed(rd_entry.top));

  always_comb begin
    sts.is_load  = (item_r.kind == KIND_LOAD);
    sts.row_occ  = occ_r[wr_addr];
    sts.row_last = (wr_addr == ADDR_W'(SLOTS - 1));
    sts.idx_last = (idx_r == ADDR_W'(SLOTS - 1));
    sts.hit_now  = occ_r[idx_r] && overlap;
    sts.cnt_full = (cnt_r == CNT_W'(MAX_RESULTS - 1));
  end

  // A hit is held back until the next hit or the finish step, so that the final one can carry last.
  always_comb begin
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;
    out_item_nxt.last = 1'b1;
    if (cmd.write) begin
      out_valid_nxt = 1'b1;
    end else if (cmd.finish) begin
      out_valid_nxt              = 1'b1;
      out_item_nxt.hit           = pend_v_r;
      out_item_nxt.first_entity  = pend_v_r ? row_r.id : '0;
      out_item_nxt.second_entity = pend_v_r ? pend_id_r : '0;
    end else if (cmd.scan && sts.hit_now && pend_v_r) begin
      out_valid_nxt              = 1'b1;
      out_item_nxt.hit           = 1'b1;
      out_item_nxt.first_entity  = row_r.id;
      out_item_nxt.second_entity = pend_id_r;
      out_item_nxt.last          = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      pend_v_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.write) begin
        occ_r[wr_addr] <= (item_r.entity_id != '0);
      end
      if (cmd.capture) begin
        pend_v_r <= 1'b0;
        cnt_r    <= '0;
      end else if (cmd.scan && sts.hit_now) begin
        pend_v_r <= 1'b1;
        cnt_r    <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= rd_addr;
    out_item_r <= out_item_nxt;
    if (cmd.capture) begin
      item_r <= in_item;
    end
    if (cmd.calc) begin
      left_r <= $signed({{2{item_r.pos_x[31]}}, item_r.pos_x}) +
                $signed({{6{item_r.offset_x[15]}}, item_r.offset_x, {FRAC_W{1'b0}}});
      top_r  <= $signed({{2{item_r.pos_y[31]}}, item_r.pos_y}) +
                $signed({{6{item_r.offset_y[15]}}, item_r.offset_y, {FRAC_W{1'b0}}});
    end
    if (cmd.lat_row) begin
      row_r <= rd_entry;
    end
    if (cmd.scan && sts.hit_now) begin
      pend_id_r <= rd_entry.id;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
